@@ design/psws_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psws_pkg
// Shared types and constants for the panel serial write sequencer.
// ----------------------------------------------------------------------------
package psws_pkg;

  localparam int QUEUE_DEPTH = 4;

  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 24;

  localparam logic [CFG_INDEX_W-1:0] CFG_PANEL_MODEL  = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_SETTLE_TICKS = 1'd1;

  localparam logic [23:0] SETTLE_RESET = 24'd100000;

  localparam logic [2:0] CMD_TICK   = 3'd0;
  localparam logic [2:0] CMD_WRITE  = 3'd1;
  localparam logic [2:0] CMD_WHITE  = 3'd2;
  localparam logic [2:0] CMD_BLACK  = 3'd3;
  localparam logic [2:0] CMD_PSAVE  = 3'd4;

  localparam logic [3:0] SQ_IDLE   = 4'd0;
  localparam logic [3:0] SQ_SINGLE = 4'd1;
  localparam logic [3:0] SQ_DREGS  = 4'd2;
  localparam logic [3:0] SQ_EXTRA  = 4'd3;
  localparam logic [3:0] SQ_W88    = 4'd4;
  localparam logic [3:0] SQ_W80    = 4'd5;
  localparam logic [3:0] SQ_SETTLE = 4'd6;
  localparam logic [3:0] SQ_PSREGS = 4'd7;
  localparam logic [3:0] SQ_P88    = 4'd8;
  localparam logic [3:0] SQ_P80    = 4'd9;
  localparam logic [3:0] SQ_P00    = 4'd10;

  localparam logic [7:0] NODE_BASE    = 8'hF0;
  localparam logic [7:0] CTRL_REFRESH = 8'h88;
  localparam logic [7:0] CTRL_LATCH   = 8'h80;
  localparam logic [7:0] CTRL_OFF     = 8'h00;
  localparam logic [7:0] PIX_WHITE    = 8'h00;
  localparam logic [7:0] PIX_BLACK    = 8'hFF;
  localparam logic [7:0] EXT0_ADDR    = 8'h04;
  localparam logic [7:0] EXT0_WHITE   = 8'hC0;
  localparam logic [7:0] EXT0_BLACK   = 8'h3F;
  localparam logic [7:0] EXT1_ADDR    = 8'h0F;
  localparam logic [7:0] EXT1_WHITE   = 8'h01;
  localparam logic [7:0] EXT1_BLACK   = 8'h02;
  localparam logic [7:0] CTRL0_ADDR   = 8'h05;
  localparam logic [7:0] CTRL1_ADDR   = 8'h10;
  localparam logic [4:0] REGS0_COUNT  = 5'd4;
  localparam logic [4:0] REGS1_COUNT  = 5'd16;

  typedef struct packed {
    logic        panel_model;
    logic [23:0] settle_ticks;
  } cfg_t;

  typedef struct packed {
    logic       start;
    logic [3:0] first_step;
    logic       white;
    logic [3:0] node_id;
    logic [7:0] reg_address;
    logic [7:0] reg_data;
    logic       sda_in;
  } entry_t;

endpackage

@@ design/psws_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psws_front
// Classifies an incoming beat into a queue entry: command or tick only,
// first sequence step and colour.
// ----------------------------------------------------------------------------
module psws_front (
  input  logic                  item_valid,
  input  logic [2:0]            cmd,
  input  logic [3:0]            node_id,
  input  logic [7:0]            reg_address,
  input  logic [7:0]            reg_data,
  input  logic                  sda_in,
  input  logic                  queue_ready,
  output logic                  item_stall,
  output logic                  push,
  output psws_pkg::entry_t      entry
);

  always_comb begin
    entry.start       = 1'b1;
    entry.first_step  = psws_pkg::SQ_IDLE;
    entry.white       = (cmd == psws_pkg::CMD_WHITE);
    entry.node_id     = node_id;
    entry.reg_address = reg_address;
    entry.reg_data    = reg_data;
    entry.sda_in      = sda_in;
    case (cmd)
      psws_pkg::CMD_WRITE: entry.first_step = psws_pkg::SQ_SINGLE;
      psws_pkg::CMD_WHITE: entry.first_step = psws_pkg::SQ_DREGS;
      psws_pkg::CMD_BLACK: entry.first_step = psws_pkg::SQ_DREGS;
      psws_pkg::CMD_PSAVE: entry.first_step = psws_pkg::SQ_PSREGS;
      default:             entry.start      = 1'b0;
    endcase
  end

  assign item_stall = !queue_ready;
  assign push       = item_valid && queue_ready;

endmodule

@@ design/psws_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psws_queue
// Short FIFO of classified beats between the front and the engine.
// ----------------------------------------------------------------------------
module psws_queue #(
  parameter int DEPTH = psws_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  psws_pkg::entry_t push_entry,
  output logic             ready,
  input  logic             pop,
  output logic             head_valid,
  output psws_pkg::entry_t head_entry
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  psws_pkg::entry_t mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign ready      = (count != CNT_W'(DEPTH));
  assign head_valid = (count != '0);
  assign head_entry = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

@@ design/psws_engine.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psws_engine
// Frame and sequence state machines: one pin event per queue beat, result
// held in an output register.
// ----------------------------------------------------------------------------
module psws_engine (
  input  logic             clk,
  input  logic             rst,
  input  psws_pkg::cfg_t   cfg,
  input  logic             head_valid,
  input  psws_pkg::entry_t head_entry,
  output logic             pop,
  output logic             result_valid,
  input  logic             result_stall,
  output logic             scl,
  output logic             sda_out,
  output logic             sda_drive,
  output logic             busy_res,
  output logic             frame_done,
  output logic             sequence_done
);

  localparam logic [2:0] PH_IDLE    = 3'd0;
  localparam logic [2:0] PH_START   = 3'd1;
  localparam logic [2:0] PH_BITHI   = 3'd2;
  localparam logic [2:0] PH_BITLO   = 3'd3;
  localparam logic [2:0] PH_ACKWAIT = 3'd4;
  localparam logic [2:0] PH_ACKLOW  = 3'd5;
  localparam logic [2:0] PH_STOP    = 3'd6;

  logic [2:0]  frame_phase, frame_phase_next;
  logic [2:0]  bit_index, bit_index_next;
  logic [1:0]  byte_slot, byte_slot_next;
  logic [3:0]  sequence_step, sequence_step_next;
  logic [4:0]  register_counter, register_counter_next;
  logic [23:0] settle_counter, settle_counter_next;
  logic [3:0]  held_node, held_node_next;
  logic [7:0]  held_address, held_address_next;
  logic [7:0]  held_data, held_data_next;
  logic        white, white_next;

  logic        o_scl, o_sda, o_drv, o_busy, o_fdone, o_sdone;
  logic [7:0]  fld_addr, fld_data, cur_byte, ctrl_addr;
  logic [4:0]  reg_count;
  logic [23:0] settle_dec;
  logic        fire;

  assign fire = head_valid && (!result_valid || !result_stall);
  assign pop  = fire;

  assign reg_count  = cfg.panel_model ? psws_pkg::REGS1_COUNT : psws_pkg::REGS0_COUNT;
  assign ctrl_addr  = cfg.panel_model ? psws_pkg::CTRL1_ADDR : psws_pkg::CTRL0_ADDR;
  assign settle_dec = settle_counter - 24'd1;

  always_comb begin
    fld_addr = 8'h00;
    fld_data = 8'h00;
    case (sequence_step)
      psws_pkg::SQ_SINGLE: begin
        fld_addr = held_address;
        fld_data = held_data;
      end
      psws_pkg::SQ_DREGS: begin
        fld_addr = {3'b000, register_counter};
        fld_data = white ? psws_pkg::PIX_WHITE : psws_pkg::PIX_BLACK;
      end
      psws_pkg::SQ_EXTRA: begin
        if (cfg.panel_model) begin
          fld_addr = psws_pkg::EXT1_ADDR;
          fld_data = white ? psws_pkg::EXT1_WHITE : psws_pkg::EXT1_BLACK;
        end else begin
          fld_addr = psws_pkg::EXT0_ADDR;
          fld_data = white ? psws_pkg::EXT0_WHITE : psws_pkg::EXT0_BLACK;
        end
      end
      psws_pkg::SQ_W88, psws_pkg::SQ_P88: begin
        fld_addr = ctrl_addr;
        fld_data = psws_pkg::CTRL_REFRESH;
      end
      psws_pkg::SQ_W80, psws_pkg::SQ_P80: begin
        fld_addr = ctrl_addr;
        fld_data = psws_pkg::CTRL_LATCH;
      end
      psws_pkg::SQ_P00: begin
        fld_addr = ctrl_addr;
        fld_data = psws_pkg::CTRL_OFF;
      end
      psws_pkg::SQ_PSREGS: begin
        fld_addr = {3'b000, register_counter};
        fld_data = psws_pkg::CTRL_OFF;
      end
      default: begin
        fld_addr = 8'h00;
        fld_data = 8'h00;
      end
    endcase
  end

  always_comb begin
    case (byte_slot)
      2'd0:    cur_byte = psws_pkg::NODE_BASE | {4'b0000, held_node};
      2'd1:    cur_byte = fld_addr;
      default: cur_byte = fld_data;
    endcase
  end

  always_comb begin
    logic [2:0] ph;
    ph                    = frame_phase;
    frame_phase_next      = frame_phase;
    bit_index_next        = bit_index;
    byte_slot_next        = byte_slot;
    sequence_step_next    = sequence_step;
    register_counter_next = register_counter;
    settle_counter_next   = settle_counter;
    held_node_next        = held_node;
    held_address_next     = held_address;
    held_data_next        = held_data;
    white_next            = white;
    o_scl   = 1'b1;
    o_sda   = 1'b1;
    o_drv   = 1'b1;
    o_busy  = 1'b1;
    o_fdone = 1'b0;
    o_sdone = 1'b0;

    if (frame_phase == PH_IDLE) begin
      if (sequence_step == psws_pkg::SQ_SETTLE) begin
        settle_counter_next = settle_dec;
        if (settle_dec == 24'd0) begin
          sequence_step_next    = psws_pkg::SQ_PSREGS;
          register_counter_next = 5'd0;
          ph                    = PH_START;
        end
      end else begin
        sequence_step_next = psws_pkg::SQ_IDLE;
        if (head_entry.start) begin
          held_node_next        = head_entry.node_id;
          held_address_next     = head_entry.reg_address;
          held_data_next        = head_entry.reg_data;
          white_next            = head_entry.white;
          register_counter_next = 5'd0;
          sequence_step_next    = head_entry.first_step;
          ph                    = PH_START;
        end else begin
          o_busy = 1'b0;
        end
      end
    end

    case (ph)
      PH_START: begin
        o_scl            = 1'b0;
        o_sda            = 1'b0;
        byte_slot_next   = 2'd0;
        bit_index_next   = 3'd7;
        frame_phase_next = PH_BITHI;
      end
      PH_BITHI: begin
        o_sda            = cur_byte[bit_index];
        frame_phase_next = PH_BITLO;
      end
      PH_BITLO: begin
        o_scl = 1'b0;
        o_sda = cur_byte[bit_index];
        if (bit_index == 3'd0) begin
          frame_phase_next = PH_ACKWAIT;
        end else begin
          bit_index_next = bit_index - 3'd1;
        end
      end
      PH_ACKWAIT: begin
        o_sda = 1'b0;
        o_drv = 1'b0;
        if (!head_entry.sda_in) begin
          frame_phase_next = PH_ACKLOW;
        end
      end
      PH_ACKLOW: begin
        o_scl = 1'b0;
        o_sda = 1'b0;
        if (byte_slot >= 2'd2) begin
          frame_phase_next = PH_STOP;
        end else begin
          byte_slot_next   = byte_slot + 2'd1;
          bit_index_next   = 3'd7;
          frame_phase_next = PH_BITHI;
        end
      end
      PH_STOP: begin
        o_fdone          = 1'b1;
        frame_phase_next = PH_START;
        case (sequence_step)
          psws_pkg::SQ_DREGS: begin
            if (({1'b0, register_counter} + 6'd1) >= {1'b0, reg_count}) begin
              sequence_step_next    = psws_pkg::SQ_EXTRA;
              register_counter_next = 5'd0;
            end else begin
              register_counter_next = register_counter + 5'd1;
            end
          end
          psws_pkg::SQ_EXTRA: sequence_step_next = psws_pkg::SQ_W88;
          psws_pkg::SQ_W88:   sequence_step_next = psws_pkg::SQ_W80;
          psws_pkg::SQ_W80: begin
            settle_counter_next   = cfg.settle_ticks;
            register_counter_next = 5'd0;
            if (cfg.settle_ticks == 24'd0) begin
              sequence_step_next = psws_pkg::SQ_PSREGS;
            end else begin
              sequence_step_next = psws_pkg::SQ_SETTLE;
              frame_phase_next   = PH_IDLE;
            end
          end
          psws_pkg::SQ_PSREGS: begin
            if (register_counter >= reg_count) begin
              sequence_step_next    = psws_pkg::SQ_P88;
              register_counter_next = 5'd0;
            end else begin
              register_counter_next = register_counter + 5'd1;
            end
          end
          psws_pkg::SQ_P88: sequence_step_next = psws_pkg::SQ_P80;
          psws_pkg::SQ_P80: sequence_step_next = psws_pkg::SQ_P00;
          default: begin
            sequence_step_next = psws_pkg::SQ_IDLE;
            frame_phase_next   = PH_IDLE;
            o_sdone            = 1'b1;
          end
        endcase
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_phase      <= PH_IDLE;
      bit_index        <= 3'd7;
      byte_slot        <= 2'd0;
      sequence_step    <= psws_pkg::SQ_IDLE;
      register_counter <= 5'd0;
      settle_counter   <= 24'd0;
      held_node        <= 4'd0;
      held_address     <= 8'd0;
      held_data        <= 8'd0;
      white            <= 1'b0;
      result_valid     <= 1'b0;
    end else begin
      if (fire) begin
        frame_phase      <= frame_phase_next;
        bit_index        <= bit_index_next;
        byte_slot        <= byte_slot_next;
        sequence_step    <= sequence_step_next;
        register_counter <= register_counter_next;
        settle_counter   <= settle_counter_next;
        held_node        <= held_node_next;
        held_address     <= held_address_next;
        held_data        <= held_data_next;
        white            <= white_next;
        result_valid     <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      scl           <= o_scl;
      sda_out       <= o_sda;
      sda_drive     <= o_drv;
      busy_res      <= o_busy;
      frame_done    <= o_fdone;
      sequence_done <= o_sdone;
    end
  end

endmodule

@@ design/panel_serial_write_sequencer_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// panel_serial_write_sequencer_unit
// Two-wire serial write master: each input beat is one line tick, each
// result beat gives the line levels and status for that tick.
// ----------------------------------------------------------------------------
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+-----------------------------------
//  item     | item_valid / item_stall   | cmd, node_id, reg_address,
//           |                           | reg_data, sda_in
//  result   | result_valid/result_stall | scl, sda_out, sda_drive,
//           |                           | busy_res, frame_done, sequence_done
//  config   | cfg_valid / cfg_ready     | cfg_index, cfg_data
//
//  One beat per cycle in and out while neither item_stall nor result_stall holds
//  the flow; a result is set in the engine's output register when its beat is popped from the head of the queue.
//  A QUEUE_DEPTH-entry queue absorbs result stalls before item_stall rises.
//  Reset clears the queue, the frame and sequence state and the config
//  registers (model 0, settle 100000 ticks); cfg_ready is always high.
//
module panel_serial_write_sequencer_unit #(
  parameter int QUEUE_DEPTH = psws_pkg::QUEUE_DEPTH
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            item_valid,
  output logic                            item_stall,
  input  logic [2:0]                      cmd,
  input  logic [3:0]                      node_id,
  input  logic [7:0]                      reg_address,
  input  logic [7:0]                      reg_data,
  input  logic                            sda_in,
  output logic                            result_valid,
  input  logic                            result_stall,
  output logic                            scl,
  output logic                            sda_out,
  output logic                            sda_drive,
  output logic                            busy_res,
  output logic                            frame_done,
  output logic                            sequence_done,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [psws_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [psws_pkg::CFG_DATA_W-1:0]  cfg_data
);

  psws_pkg::cfg_t   cfg;
  psws_pkg::entry_t push_entry;
  psws_pkg::entry_t head_entry;
  logic             push, pop, queue_ready, head_valid;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.panel_model  <= 1'b0;
      cfg.settle_ticks <= psws_pkg::SETTLE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        psws_pkg::CFG_PANEL_MODEL:  cfg.panel_model  <= cfg_data[0];
        psws_pkg::CFG_SETTLE_TICKS: cfg.settle_ticks <= cfg_data[23:0];
        default: begin
        end
      endcase
    end
  end

  psws_front u_front (
    .item_valid  (item_valid),
    .cmd         (cmd),
    .node_id     (node_id),
    .reg_address (reg_address),
    .reg_data    (reg_data),
    .sda_in      (sda_in),
    .queue_ready (queue_ready),
    .item_stall  (item_stall),
    .push        (push),
    .entry       (push_entry)
  );

  psws_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .ready      (queue_ready),
    .pop        (pop),
    .head_valid (head_valid),
    .head_entry (head_entry)
  );

  psws_engine u_engine (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .head_valid    (head_valid),
    .head_entry    (head_entry),
    .pop           (pop),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .scl           (scl),
    .sda_out       (sda_out),
    .sda_drive     (sda_drive),
    .busy_res      (busy_res),
    .frame_done    (frame_done),
    .sequence_done (sequence_done)
  );

endmodule

@@ dv/panel_serial_write_sequencer_unit_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// panel_serial_write_sequencer_unit_tb
// Self-checking bench for the two-wire panel write master. Line ticks go in
// one beat at a time. A behavioural model of the frame and sequence engine
// predicts the line levels for every accepted beat, and each result beat is
// checked in order against it. Covers ignored codes, a single write,
// acknowledge stretching, a refresh list with panel changes part way through
// and a latched settle wait, random traffic and a long output hold-off.
// ----------------------------------------------------------------------------
module panel_serial_write_sequencer_unit_tb;

  localparam int CYCLE_LIMIT = 20000;
  localparam int HOLD_CYCLES = 300;
  localparam int ITEM_BUDGET = 1050;

  localparam logic [2:0] FR_IDLE     = 3'd0;
  localparam logic [2:0] FR_START    = 3'd1;
  localparam logic [2:0] FR_BIT_HI   = 3'd2;
  localparam logic [2:0] FR_BIT_LO   = 3'd3;
  localparam logic [2:0] FR_ACK_WAIT = 3'd4;
  localparam logic [2:0] FR_ACK_LOW  = 3'd5;
  localparam logic [2:0] FR_STOP     = 3'd6;

  typedef struct packed {
    logic scl;
    logic sda_out;
    logic sda_drive;
    logic busy;
    logic frame_done;
    logic sequence_done;
  } line_levels_t;

  logic                             clk          = 1'b0;
  logic                             rst          = 1'b1;
  logic                             item_valid   = 1'b0;
  logic                             item_stall;
  logic [2:0]                       cmd          = psws_pkg::CMD_TICK;
  logic [3:0]                       node_id      = '0;
  logic [7:0]                       reg_address  = '0;
  logic [7:0]                       reg_data     = '0;
  logic                             sda_in       = 1'b1;
  logic                             result_valid;
  logic                             result_stall = 1'b0;
  logic                             scl;
  logic                             sda_out;
  logic                             sda_drive;
  logic                             busy_res;
  logic                             frame_done;
  logic                             sequence_done;
  logic                             cfg_valid    = 1'b0;
  logic                             cfg_ready;
  logic [psws_pkg::CFG_INDEX_W-1:0] cfg_index    = psws_pkg::CFG_PANEL_MODEL;
  logic [psws_pkg::CFG_DATA_W-1:0]  cfg_data     = '0;

  // bus model state, mirrors the block after every accepted beat
  logic         bus_model        = 1'b0;
  logic [23:0]  bus_settle_ticks = psws_pkg::SETTLE_RESET;
  logic [2:0]   bus_phase        = FR_IDLE;
  logic [2:0]   bus_bit          = 3'd7;
  logic [1:0]   bus_slot         = '0;
  logic [3:0]   bus_step         = psws_pkg::SQ_IDLE;
  logic [4:0]   bus_count        = '0;
  logic [23:0]  bus_settle_left  = '0;
  logic [3:0]   bus_node         = '0;
  logic [7:0]   bus_addr         = '0;
  logic [7:0]   bus_data         = '0;
  logic [2:0]   bus_cmd          = psws_pkg::CMD_TICK;

  line_levels_t expected_lines[$];
  line_levels_t want_line;
  line_levels_t seen_line;
  int           line_errors = 0;
  int           cycle_count = 0;
  int           items_sent  = 0;
  int           ack_pct     = 75;
  int           hold_left   = 0;
  bit           hold_req    = 1'b0;
  bit           steady      = 1'b0;

  panel_serial_write_sequencer_unit u_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .cmd          (cmd),
    .node_id      (node_id),
    .reg_address  (reg_address),
    .reg_data     (reg_data),
    .sda_in       (sda_in),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .scl          (scl),
    .sda_out      (sda_out),
    .sda_drive    (sda_drive),
    .busy_res     (busy_res),
    .frame_done   (frame_done),
    .sequence_done(sequence_done),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #6 clk = ~clk;

  function automatic int regs_in_model();
    return bus_model ? int'(psws_pkg::REGS1_COUNT) : int'(psws_pkg::REGS0_COUNT);
  endfunction

  function automatic logic [7:0] ctrl_addr();
    return bus_model ? psws_pkg::CTRL1_ADDR : psws_pkg::CTRL0_ADDR;
  endfunction

  function automatic bit bus_idle();
    return bus_phase == FR_IDLE && bus_step != psws_pkg::SQ_SETTLE;
  endfunction

  function automatic logic [7:0] frame_byte();
    logic [7:0] a;
    logic [7:0] d;
    logic       white;
    white = (bus_cmd == psws_pkg::CMD_WHITE);
    a = '0;
    d = '0;
    if (bus_slot == 2'd0) return psws_pkg::NODE_BASE + {4'h0, bus_node};
    case (bus_step)
      psws_pkg::SQ_SINGLE: begin
        a = bus_addr;
        d = bus_data;
      end
      psws_pkg::SQ_DREGS: begin
        a = {3'b000, bus_count};
        d = white ? psws_pkg::PIX_WHITE : psws_pkg::PIX_BLACK;
      end
      psws_pkg::SQ_EXTRA: begin
        if (bus_model) begin
          a = psws_pkg::EXT1_ADDR;
          d = white ? psws_pkg::EXT1_WHITE : psws_pkg::EXT1_BLACK;
        end else begin
          a = psws_pkg::EXT0_ADDR;
          d = white ? psws_pkg::EXT0_WHITE : psws_pkg::EXT0_BLACK;
        end
      end
      psws_pkg::SQ_W88, psws_pkg::SQ_P88: begin
        a = ctrl_addr();
        d = psws_pkg::CTRL_REFRESH;
      end
      psws_pkg::SQ_W80, psws_pkg::SQ_P80: begin
        a = ctrl_addr();
        d = psws_pkg::CTRL_LATCH;
      end
      psws_pkg::SQ_P00: begin
        a = ctrl_addr();
        d = psws_pkg::CTRL_OFF;
      end
      psws_pkg::SQ_PSREGS: begin
        a = {3'b000, bus_count};
        d = psws_pkg::CTRL_OFF;
      end
      default: ;
    endcase
    return (bus_slot == 2'd1) ? a : d;
  endfunction

  // advance the write list after a stop; high when the command is over
  function automatic logic close_frame();
    case (bus_step)
      psws_pkg::SQ_DREGS: begin
        if (int'(bus_count) + 1 >= regs_in_model()) begin
          bus_step  = psws_pkg::SQ_EXTRA;
          bus_count = '0;
        end else begin
          bus_count++;
        end
      end
      psws_pkg::SQ_EXTRA: bus_step = psws_pkg::SQ_W88;
      psws_pkg::SQ_W88:   bus_step = psws_pkg::SQ_W80;
      psws_pkg::SQ_W80: begin
        bus_settle_left = bus_settle_ticks;
        bus_count       = '0;
        if (bus_settle_left == '0) begin
          bus_step = psws_pkg::SQ_PSREGS;
        end else begin
          bus_step  = psws_pkg::SQ_SETTLE;
          bus_phase = FR_IDLE;
          return 1'b0;
        end
      end
      psws_pkg::SQ_PSREGS: begin
        if (int'(bus_count) + 1 >= regs_in_model() + 1) begin
          bus_step  = psws_pkg::SQ_P88;
          bus_count = '0;
        end else begin
          bus_count++;
        end
      end
      psws_pkg::SQ_P88: bus_step = psws_pkg::SQ_P80;
      psws_pkg::SQ_P80: bus_step = psws_pkg::SQ_P00;
      default: begin
        bus_step  = psws_pkg::SQ_IDLE;
        bus_phase = FR_IDLE;
        bus_cmd   = psws_pkg::CMD_TICK;
        return 1'b1;
      end
    endcase
    bus_phase = FR_START;
    return 1'b0;
  endfunction

  function automatic line_levels_t predict_line_levels(input logic [2:0] c,
                                                       input logic [3:0] n,
                                                       input logic [7:0] a,
                                                       input logic [7:0] d,
                                                       input logic       s);
    line_levels_t lv;
    logic [7:0]   b;
    lv = '{scl: 1'b1, sda_out: 1'b1, sda_drive: 1'b1, busy: 1'b1,
           frame_done: 1'b0, sequence_done: 1'b0};
    if (bus_phase == FR_IDLE) begin
      if (bus_step == psws_pkg::SQ_SETTLE) begin
        bus_settle_left = bus_settle_left - 24'd1;
        if (bus_settle_left == '0) begin
          bus_step  = psws_pkg::SQ_PSREGS;
          bus_count = '0;
          bus_phase = FR_START;
        end
      end else begin
        bus_step = psws_pkg::SQ_IDLE;
        if (c >= psws_pkg::CMD_WRITE && c <= psws_pkg::CMD_PSAVE) begin
          bus_node  = n;
          bus_addr  = a;
          bus_data  = d;
          bus_cmd   = c;
          bus_count = '0;
          bus_step  = (c == psws_pkg::CMD_WRITE) ? psws_pkg::SQ_SINGLE :
                      (c == psws_pkg::CMD_PSAVE) ? psws_pkg::SQ_PSREGS : psws_pkg::SQ_DREGS;
          bus_phase = FR_START;
        end else begin
          lv.busy = 1'b0;
        end
      end
    end
    case (bus_phase)
      FR_START: begin
        lv.scl     = 1'b0;
        lv.sda_out = 1'b0;
        bus_slot   = '0;
        bus_bit    = 3'd7;
        bus_phase  = FR_BIT_HI;
      end
      FR_BIT_HI: begin
        b          = frame_byte();
        lv.sda_out = b[bus_bit];
        bus_phase  = FR_BIT_LO;
      end
      FR_BIT_LO: begin
        b          = frame_byte();
        lv.scl     = 1'b0;
        lv.sda_out = b[bus_bit];
        if (bus_bit == 3'd0) bus_phase = FR_ACK_WAIT;
        else bus_bit--;
      end
      FR_ACK_WAIT: begin
        lv.sda_out   = 1'b0;
        lv.sda_drive = 1'b0;
        if (!s) bus_phase = FR_ACK_LOW;
      end
      FR_ACK_LOW: begin
        lv.scl     = 1'b0;
        lv.sda_out = 1'b0;
        if (bus_slot >= 2'd2) begin
          bus_phase = FR_STOP;
        end else begin
          bus_slot++;
          bus_bit   = 3'd7;
          bus_phase = FR_BIT_HI;
        end
      end
      FR_STOP: begin
        lv.frame_done    = 1'b1;
        lv.sequence_done = close_frame();
      end
      default: ;
    endcase
    return lv;
  endfunction

  task automatic send_tick(input logic [2:0] c, input logic [3:0] n, input logic [7:0] a,
                           input logic [7:0] d, input logic s);
    if (!steady && $urandom_range(99) < 9) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk);
    end
    item_valid  <= 1'b1;
    cmd         <= c;
    node_id     <= n;
    reg_address <= a;
    reg_data    <= d;
    sda_in      <= s;
    do @(posedge clk); while (item_stall);
    items_sent++;
    expected_lines.push_back(predict_line_levels(c, n, a, d, s));
  endtask

  // any code while busy; the slave answers an acknowledge at ack_pct
  task automatic send_filler();
    logic s;
    if (bus_phase == FR_ACK_WAIT) s = ($urandom_range(99) < ack_pct) ? 1'b0 : 1'b1;
    else s = 1'($urandom_range(1));
    send_tick(3'($urandom_range(7)), 4'($urandom_range(15)), 8'($urandom()),
              8'($urandom()), s);
  endtask

  task automatic start_command(input logic [2:0] c, input logic [3:0] n,
                               input logic [7:0] a, input logic [7:0] d);
    send_tick(c, n, a, d, 1'($urandom_range(1)));
  endtask

  task automatic finish_command();
    while (!bus_idle()) send_filler();
  endtask

  task automatic wait_drained();
    item_valid <= 1'b0;
    do @(posedge clk); while (expected_lines.size() != 0);
  endtask

  task automatic set_panel(input logic model, input logic [23:0] settle);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_index <= psws_pkg::CFG_PANEL_MODEL;
    cfg_data  <= {23'b0, model};
    do @(posedge clk); while (!cfg_ready);
    bus_model = model;
    cfg_index <= psws_pkg::CFG_SETTLE_TICKS;
    cfg_data  <= settle;
    do @(posedge clk); while (!cfg_ready);
    bus_settle_ticks = settle;
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [2:0] idle_code();
    int r;
    r = $urandom_range(3);
    return (r == 0) ? psws_pkg::CMD_TICK : psws_pkg::CMD_PSAVE + 3'(r);
  endfunction

  task automatic test_ignored_codes();
    send_tick(psws_pkg::CMD_TICK, 4'h0, 8'h00, 8'h00, 1'b0);
    send_tick(psws_pkg::CMD_TICK, 4'hF, 8'hFF, 8'hFF, 1'b1);
    for (int k = 1; k <= 3; k++) begin
      send_tick(psws_pkg::CMD_PSAVE + 3'(k), 4'hF, 8'hFF, 8'hFF, 1'b1);
    end
  endtask

  task automatic test_single_writes();
    set_panel(1'b0, 24'd3);
    start_command(psws_pkg::CMD_WRITE, 4'hF, 8'h00, 8'hFF);
    finish_command();
  endtask

  task automatic test_ack_stretch();
    start_command(psws_pkg::CMD_WRITE, 4'h3, 8'h3C, 8'hC3);
    ack_pct = 0;
    while (bus_phase != FR_ACK_WAIT) send_filler();
    repeat (16) send_filler();
    ack_pct = 75;
    finish_command();
  endtask

  // no idling here; hold the results off so the queue fills
  task automatic test_refresh_panel_switch();
    set_panel(1'b1, 24'd3);
    steady   = 1'b1;
    hold_req = 1'b1;
    start_command(psws_pkg::CMD_WHITE, 4'h6, 8'($urandom()), 8'($urandom()));
    while (!(bus_step == psws_pkg::SQ_DREGS && bus_count == 5'd1)) send_filler();
    set_panel(1'b0, 24'd3);
    while (bus_step != psws_pkg::SQ_EXTRA) send_filler();
    set_panel(1'b1, 24'd3);
    while (bus_step != psws_pkg::SQ_SETTLE) send_filler();
    set_panel(1'b0, 24'hFF_FFFF);
    while (bus_step != psws_pkg::SQ_P88) send_filler();
    set_panel(1'b1, 24'hFF_FFFF);
    finish_command();
    steady = 1'b0;
  endtask

  task automatic test_random_traffic();
    int         r;
    logic [2:0] c;
    set_panel(1'b0, 24'd7);
    while (items_sent < ITEM_BUDGET) begin
      if (bus_idle()) begin
        if ($urandom_range(99) < 8)
          set_panel(1'($urandom_range(3) == 0), 24'($urandom_range(12)));
        r = $urandom_range(99);
        if (r < 20) begin
          send_tick(idle_code(), 4'($urandom_range(15)), 8'($urandom()), 8'($urandom()),
                    1'($urandom_range(1)));
        end else begin
          c = (r < 60) ? psws_pkg::CMD_WRITE : (r < 80) ? psws_pkg::CMD_PSAVE :
              (r < 90) ? psws_pkg::CMD_WHITE : psws_pkg::CMD_BLACK;
          ack_pct = $urandom_range(95, 40);
          start_command(c, 4'($urandom_range(15)), 8'($urandom()), 8'($urandom()));
        end
      end else begin
        send_filler();
      end
    end
  endtask

  task automatic check_bit(input string name, input logic want, input logic got);
    if (want !== got) begin
      line_errors++;
      if (line_errors <= 10) $display("mismatch %s: expected %b, got %b", name, want, got);
    end
  endtask

  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      seen_line = '{scl: scl, sda_out: sda_out, sda_drive: sda_drive, busy: busy_res,
                    frame_done: frame_done, sequence_done: sequence_done};
      if (expected_lines.size() == 0) begin
        line_errors++;
        if (line_errors <= 10) $display("mismatch: result beat with nothing expected");
      end else begin
        want_line = expected_lines.pop_front();
        check_bit("scl", want_line.scl, seen_line.scl);
        check_bit("sda_out", want_line.sda_out, seen_line.sda_out);
        check_bit("sda_drive", want_line.sda_drive, seen_line.sda_drive);
        check_bit("busy_res", want_line.busy, seen_line.busy);
        check_bit("frame_done", want_line.frame_done, seen_line.frame_done);
        check_bit("sequence_done", want_line.sequence_done, seen_line.sequence_done);
      end
    end
  end

  always @(posedge clk) begin
    if (hold_left > 0) begin
      result_stall <= 1'b1;
      hold_left--;
    end else if (hold_req) begin
      hold_req     = 1'b0;
      hold_left    = HOLD_CYCLES;
      result_stall <= 1'b1;
    end else begin
      result_stall <= !steady && ($urandom_range(99) < 16);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_ignored_codes();
    test_single_writes();
    test_ack_stretch();
    test_refresh_panel_switch();
    test_random_traffic();
    wait_drained();
    repeat (16) @(posedge clk);
    if (line_errors == 0 && expected_lines.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

@@ panel_serial_write_sequencer_unit.f @@
design/psws_pkg.sv
design/psws_front.sv
design/psws_queue.sv
design/psws_engine.sv
design/panel_serial_write_sequencer_unit.sv
dv/panel_serial_write_sequencer_unit_tb.sv
